// ----- hdl/plm_pkg.sv -----
// Package: shared constants and types for the positional list manager.
`default_nettype none
package plm_pkg;
	localparam int CAPACITY   = 64;
	localparam int VALUE_BITS = 32;
	localparam int SLOT_BITS  = $clog2(CAPACITY);
	localparam int CNT_BITS   = $clog2(CAPACITY + 1);

	localparam logic [2:0] OP_INS_FRONT = 3'd0;
	localparam logic [2:0] OP_INS_BACK  = 3'd1;
	localparam logic [2:0] OP_INS_POS   = 3'd2;
	localparam logic [2:0] OP_DEL_FRONT = 3'd3;
	localparam logic [2:0] OP_DEL_BACK  = 3'd4;
	localparam logic [2:0] OP_DEL_POS   = 3'd5;
	localparam logic [2:0] OP_SEARCH    = 3'd6;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_EMPTY    = 3'd1;
	localparam logic [2:0] ST_FULL     = 3'd2;
	localparam logic [2:0] ST_BAD_POS  = 3'd3;
	localparam logic [2:0] ST_NOTFOUND = 3'd4;

	typedef struct packed {
		logic load;      // latch item, start walk from first
		logic step;      // advance walk one link
		logic fetch;     // read current slot into data regs
		logic do_ins;    // apply insert
		logic do_del;    // apply delete
		logic emit;      // copy result fields into output register
	} plm_cmd_t;

	typedef struct packed {
		logic [2:0]          op;
		logic [CNT_BITS-1:0] count;
		logic [CNT_BITS-1:0] idx;     // walk index of current slot
		logic [CNT_BITS-1:0] target;  // walk stop index
		logic                match;   // fetched value equals key
		logic [7:0]          pos;
	} plm_stat_t;
endpackage
`default_nettype wire

// ----- hdl/plm_datapath.sv -----
// Datapath: slot memories, list pointers, walk register and result fields.
`default_nettype none
module plm_datapath (
	input  wire                          clk,
	input  wire                          arst_n,
	input  plm_pkg::plm_cmd_t            cmd,
	output plm_pkg::plm_stat_t           stat,
	input  wire [2:0]                    in_op,
	input  wire [31:0]                   in_value,
	input  wire [7:0]                    in_pos,
	output logic [plm_pkg::CNT_BITS-1:0] count_out,
	output logic signed [31:0]           rem_value
);
	import plm_pkg::*;

	logic [VALUE_BITS-1:0] val_mem [CAPACITY];
	logic [SLOT_BITS-1:0]  nxt_mem [CAPACITY];
	logic [SLOT_BITS-1:0]  prv_mem [CAPACITY];
	logic [CAPACITY-1:0]   used_q;
	logic [SLOT_BITS-1:0]  first_q, last_q, cur_q;
	logic [CNT_BITS-1:0]   count_q, idx_q;
	logic [2:0]            op_q;
	logic [7:0]            pos_q;
	logic [VALUE_BITS-1:0] key_q, rd_val_q, rem_q;
	logic [SLOT_BITS-1:0]  rd_nxt_q, rd_prv_q;
	logic [SLOT_BITS-1:0]  free_s;
	logic [CNT_BITS-1:0]   target;
	logic [CNT_BITS:0]     pos_m1;

	always_comb begin
		free_s = '0;
		for (int i = CAPACITY - 1; i >= 0; i--)
			if (!used_q[i]) free_s = SLOT_BITS'(i);
	end

	// index of slot visited: insert walks to k-1, delete walks to k
	always_comb begin
		pos_m1 = {1'b0, CNT_BITS'(pos_q)} - 1'b1;
		if (pos_q > 8'(CAPACITY)) pos_m1 = (CNT_BITS+1)'(CAPACITY);
		target = '0;
		case (op_q)
			OP_INS_POS: target = pos_m1[CNT_BITS-1:0] - 1'b1;
			OP_DEL_BACK: target = count_q - 1'b1;
			OP_DEL_POS: target = (pos_m1 < {1'b0, count_q}) ? pos_m1[CNT_BITS-1:0]
			                                               : count_q - 1'b1;
			default: target = '0;
		endcase
	end

	assign stat = '{op: op_q, count: count_q, idx: idx_q, target: target,
	                match: (rd_val_q == key_q), pos: pos_q};

	always_ff @(posedge clk) begin
		if (cmd.fetch) begin
			rd_val_q <= val_mem[cur_q];
			rd_nxt_q <= nxt_mem[cur_q];
			rd_prv_q <= prv_mem[cur_q];
		end
		if (cmd.load) begin
			key_q <= in_value[VALUE_BITS-1:0];
			pos_q <= in_pos;
		end
		if (cmd.do_ins) begin
			val_mem[free_s] <= key_q;
			if (count_q == '0) begin
			end else if (op_q == OP_INS_FRONT ||
			             (op_q == OP_INS_POS && (pos_q == 8'd1))) begin
				nxt_mem[free_s]  <= first_q;
				prv_mem[first_q] <= free_s;
			end else if (op_q == OP_INS_BACK ||
			             {1'b0, pos_m1[CNT_BITS-1:0]} >= {1'b0, count_q} ||
			             pos_m1[CNT_BITS]) begin
				prv_mem[free_s] <= last_q;
				nxt_mem[last_q] <= free_s;
			end else begin
				prv_mem[free_s]   <= cur_q;
				nxt_mem[free_s]   <= rd_nxt_q;
				nxt_mem[cur_q]    <= free_s;
				prv_mem[rd_nxt_q] <= free_s;
			end
		end
		if (cmd.do_del && count_q != CNT_BITS'(1) && idx_q != '0 &&
		    idx_q != count_q - 1'b1) begin
			nxt_mem[rd_prv_q] <= rd_nxt_q;
			prv_mem[rd_nxt_q] <= rd_prv_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q    <= '0;
			first_q   <= '0;
			last_q    <= '0;
			count_q   <= '0;
			cur_q     <= '0;
			idx_q     <= '0;
			op_q      <= '0;
			rem_q     <= '0;
			rem_value <= '0;
			count_out <= '0;
		end else begin
			if (cmd.load) begin
				op_q  <= in_op;
				cur_q <= first_q;
				idx_q <= '0;
				rem_q <= '0;
			end
			if (cmd.step) begin
				cur_q <= rd_nxt_q;
				idx_q <= idx_q + 1'b1;
			end
			if (cmd.do_ins) begin
				used_q[free_s] <= 1'b1;
				count_q <= count_q + 1'b1;
				if (count_q == '0) begin
					first_q <= free_s;
					last_q  <= free_s;
				end else if (op_q == OP_INS_FRONT ||
				             (op_q == OP_INS_POS && pos_q == 8'd1)) begin
					first_q <= free_s;
				end else if (op_q == OP_INS_BACK ||
				             {1'b0, pos_m1[CNT_BITS-1:0]} >= {1'b0, count_q} ||
				             pos_m1[CNT_BITS]) begin
					last_q <= free_s;
				end
			end
			if (cmd.do_del) begin
				used_q[cur_q] <= 1'b0;
				count_q <= count_q - 1'b1;
				rem_q   <= rd_val_q;
				if (count_q == CNT_BITS'(1)) begin
					first_q <= '0;
					last_q  <= '0;
				end else if (idx_q == '0) begin
					first_q <= rd_nxt_q;
				end else if (idx_q == count_q - 1'b1) begin
					last_q <= rd_prv_q;
				end
			end
			if (cmd.emit) begin
				rem_value <= 32'(signed'(rem_q));
				count_out <= count_q;
			end
		end
	end
endmodule
`default_nettype wire

// ----- hdl/plm_controller.sv -----
// Controller: sequences walks and updates, and holds the result register.
`default_nettype none
module plm_controller (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          in_fire,
	output logic                         busy,
	output plm_pkg::plm_cmd_t            cmd,
	input  plm_pkg::plm_stat_t           stat,
	output logic                         res_valid,
	input  wire                          res_ready,
	output logic [2:0]                   res_status,
	output logic [6:0]                   res_found
);
	import plm_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0, S_DEC = 3'd1, S_FETCH = 3'd2,
	                       S_EVAL = 3'd3, S_OUT = 3'd4;
	logic [2:0] state_q;
	logic [2:0] st_q;
	logic [6:0] fnd_q;
	logic       ins_op, del_op;

	assign ins_op = stat.op == OP_INS_FRONT || stat.op == OP_INS_BACK ||
	                stat.op == OP_INS_POS;
	assign del_op = stat.op == OP_DEL_FRONT || stat.op == OP_DEL_BACK ||
	                stat.op == OP_DEL_POS;
	assign busy = (state_q != S_IDLE);

	always_comb begin
		cmd = '0;
		cmd.load  = in_fire;
		cmd.fetch = (state_q == S_FETCH);
		cmd.emit  = (state_q == S_OUT) && !res_valid;
		if (state_q == S_EVAL) begin
			if (ins_op) begin
				if (stat.op != OP_INS_POS || stat.idx >= stat.target ||
				    stat.idx + 1'b1 >= stat.count) cmd.do_ins = 1'b1;
				else cmd.step = 1'b1;
			end else if (del_op) begin
				if (stat.idx == stat.target) cmd.do_del = 1'b1;
				else cmd.step = 1'b1;
			end else if (!stat.match && stat.idx + 1'b1 < stat.count) begin
				cmd.step = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			res_valid  <= 1'b0;
			res_status <= ST_OK;
			res_found  <= '0;
			st_q       <= ST_OK;
			fnd_q      <= '0;
		end else begin
			if (res_valid && res_ready) res_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: if (in_fire) state_q <= S_DEC;
				S_DEC: begin
					st_q    <= ST_OK;
					fnd_q   <= '0;
					state_q <= S_OUT;
					if (ins_op) begin
						if (stat.op == OP_INS_POS && stat.pos == 8'd0) st_q <= ST_BAD_POS;
						else if (stat.count >= CNT_BITS'(CAPACITY)) st_q <= ST_FULL;
						else state_q <= S_FETCH;
					end else if (del_op || stat.op == OP_SEARCH) begin
						if (stat.count == '0) st_q <= ST_EMPTY;
						else if (stat.op == OP_DEL_POS && stat.pos == 8'd0)
							st_q <= ST_BAD_POS;
						else state_q <= S_FETCH;
					end
				end
				S_FETCH: state_q <= S_EVAL;
				S_EVAL: begin
					if (cmd.step) state_q <= S_FETCH;
					else begin
						state_q <= S_OUT;
						if (stat.op == OP_SEARCH) begin
							if (stat.match) fnd_q <= 7'(stat.idx + 1'b1);
							else st_q <= ST_NOTFOUND;
						end
					end
				end
				S_OUT: if (!res_valid) begin
					res_valid  <= 1'b1;
					res_status <= st_q;
					res_found  <= fnd_q;
					state_q    <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ----- hdl/positional_list_manager.sv -----
// Top level of the positional list manager.
// Use: one input transaction per operation on s_axis, one result on m_axis.
// s_axis_tdata: op[2:0], value[34:3], position[42:35], zero fill to 48 bits.
// m_axis_tdata: status[2:0], removed_value[34:3], found_position[41:35],
// length[48:42], zero fill to 56 bits.
// Sequence: a rejected item or an unused op goes from decode straight to
// the output state; every other item passes decode, then a memory read and
// an evaluate for each list entry visited, then the output state. Front and
// back insert and front delete walk nothing; back delete, positional
// operations and search walk up the list. The walk through next links, one
// slot per read, sets the worst case.
// One item is in flight at a time; s_axis_tready is low while busy and rises
// in the cycle the result is presented.
// Reset empties the list at once; no clearing pass is needed.
// A stalled receiver holds the output register; the next item may be taken
// while it waits, and its result waits until the register frees.
`default_nettype none
module positional_list_manager (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        s_axis_tvalid,
	output logic       s_axis_tready,
	input  wire [47:0] s_axis_tdata,   // op, value, position
	output logic       m_axis_tvalid,
	input  wire        m_axis_tready,
	output logic [55:0] m_axis_tdata   // status, removed_value, found_position, length
);
	import plm_pkg::*;

	plm_cmd_t            cmd;
	plm_stat_t           stat;
	logic                busy, fire;
	logic [2:0]          res_status;
	logic [6:0]          res_found;
	logic [CNT_BITS-1:0] count_out;
	logic signed [31:0]  rem_value;

	assign s_axis_tready = !busy;
	assign fire = s_axis_tvalid && s_axis_tready;

	plm_controller u_ctrl (
		.clk, .arst_n, .in_fire(fire), .busy, .cmd, .stat,
		.res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res_status, .res_found
	);

	plm_datapath u_dp (
		.clk, .arst_n, .cmd, .stat,
		.in_op(s_axis_tdata[2:0]), .in_value(s_axis_tdata[34:3]),
		.in_pos(s_axis_tdata[42:35]), .count_out, .rem_value
	);

	assign m_axis_tdata = {7'd0, count_out, res_found, rem_value, res_status};
endmodule
`default_nettype wire

// ----- hdl/plm_checker.sv -----
// Checker: port-level assertions for the positional list manager.
`default_nettype none
module plm_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        s_axis_tvalid,
	input wire        s_axis_tready,
	input wire        m_axis_tvalid,
	input wire        m_axis_tready,
	input wire [55:0] m_axis_tdata
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");
	a_len: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[48:42] <= 7'd64)
		else $error("length above capacity");
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[2:0] <= 3'd4)
		else $error("bad status code");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("accepted two items back to back");
endmodule

bind positional_list_manager plm_checker u_plm_checker (
	.clk, .arst_n, .s_axis_tvalid, .s_axis_tready,
	.m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);
`default_nettype wire

// ----- verif/tb_positional_list_manager.sv -----
// Testbench for the positional list manager: directed and random list operations, checked by a scoreboard.
`timescale 1ns / 100ps
`default_nettype none
module tb_positional_list_manager;
	import plm_pkg::*;

	typedef struct packed {
		logic [6:0]  length;
		logic [6:0]  found_position;
		logic [31:0] removed_value;
		logic [2:0]  status;
	} list_result_t;

	class list_scoreboard;
		logic signed [31:0] entries[$];
		list_result_t       pending[$];
		int                 mismatches;
		int                 checked;

		function void note_op(logic [2:0] op, logic signed [31:0] value, logic [7:0] position);
			list_result_t r;
			int k;
			r = '0;
			r.status = ST_OK;
			case (op)
				OP_INS_FRONT, OP_INS_BACK: begin
					if (entries.size() >= CAPACITY) r.status = ST_FULL;
					else if (op == OP_INS_FRONT) entries.push_front(value);
					else entries.push_back(value);
				end
				OP_INS_POS: begin
					if (position == 0) r.status = ST_BAD_POS;
					else if (entries.size() >= CAPACITY) r.status = ST_FULL;
					else begin
						k = position - 1;
						if (k > entries.size()) k = entries.size();
						entries.insert(k, value);
					end
				end
				OP_DEL_FRONT, OP_DEL_BACK, OP_DEL_POS: begin
					if (entries.size() == 0) r.status = ST_EMPTY;
					else if (op == OP_DEL_POS && position == 0) r.status = ST_BAD_POS;
					else begin
						if (op == OP_DEL_FRONT) k = 0;
						else if (op == OP_DEL_BACK) k = entries.size() - 1;
						else k = ((position < entries.size()) ? position : entries.size()) - 1;
						r.removed_value = entries[k];
						entries.delete(k);
					end
				end
				OP_SEARCH: begin
					if (entries.size() == 0) r.status = ST_EMPTY;
					else begin
						r.status = ST_NOTFOUND;
						for (int i = 0; i < entries.size(); i++)
							if (entries[i] == value) begin
								r.found_position = 7'(i + 1);
								r.status = ST_OK;
								break;
							end
					end
				end
				default: ;
			endcase
			r.length = 7'(entries.size());
			pending.push_back(r);
		endfunction

		function void check_result(list_result_t got);
			list_result_t want;
			checked++;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %h", got);
				return;
			end
			want = pending.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch #%0d: want st=%0d rm=%0d fp=%0d len=%0d, got st=%0d rm=%0d fp=%0d len=%0d",
						checked, want.status, $signed(want.removed_value), want.found_position,
						want.length, got.status, $signed(got.removed_value),
						got.found_position, got.length);
			end
		endfunction
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_axis_tvalid = 0;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 0;
	logic [55:0] m_axis_tdata;

	list_scoreboard board = new();
	bit  quiet = 0;
	bit  sink_hold = 0;
	int  cycles = 0;
	int  sent = 0;
	logic signed [31:0] recent[$];

	always #1 clk = ~clk;

	positional_list_manager u_dut (.*);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("** positional_list_manager: FAILED **");
			$finish;
		end
	end

	always @(posedge clk)
		if (arst_n && m_axis_tvalid && m_axis_tready)
			board.check_result(list_result_t'(m_axis_tdata[48:0]));

	initial begin
		int gap;
		@(posedge clk);
		while (1) begin
			if (sink_hold) m_axis_tready <= 0;
			else if (!quiet && $urandom_range(0, 3) == 0) begin
				gap = $urandom_range(1, 17);
				m_axis_tready <= 0;
				repeat (gap) @(posedge clk);
				m_axis_tready <= 1;
			end else m_axis_tready <= 1;
			@(posedge clk);
		end
	end

	task automatic send_op(logic [2:0] op, logic signed [31:0] value, logic [7:0] position);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			s_axis_tvalid <= 0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tdata <= {5'b0, position, value, op};
		do @(posedge clk); while (!s_axis_tready);
		board.note_op(op, value, position);
		sent++;
		if (op <= OP_INS_POS) begin
			recent.push_back(value);
			if (recent.size() > 16) void'(recent.pop_front());
		end
	endtask

	task automatic drain();
		s_axis_tvalid <= 0;
		while (board.pending.size() != 0) @(posedge clk);
	endtask

	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(0, 5))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return $urandom_range(0, 7);
			default: return $urandom();
		endcase
	endfunction

	task automatic random_op();
		logic [2:0] op;
		logic [7:0] pos;
		logic signed [31:0] v;
		int r;
		int len;
		len = board.entries.size();
		r = $urandom_range(0, 99);
		if (r < 15) op = OP_INS_FRONT;
		else if (r < 30) op = OP_INS_BACK;
		else if (r < 48) op = OP_INS_POS;
		else if (r < 56) op = OP_DEL_FRONT;
		else if (r < 64) op = OP_DEL_BACK;
		else if (r < 78) op = OP_DEL_POS;
		else if (r < 97) op = OP_SEARCH;
		else op = 3'd7;
		r = $urandom_range(0, 9);
		if (r == 0) pos = 0;
		else if (r == 1) pos = 8'($urandom_range(0, 255));
		else pos = 8'($urandom_range(1, len + 2));
		v = pick_value();
		if (op == OP_SEARCH && recent.size() != 0 && $urandom_range(0, 2) != 0)
			v = recent[$urandom_range(0, recent.size() - 1)];
		send_op(op, v, pos);
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		send_op(OP_DEL_FRONT, 0, 0);
		send_op(OP_DEL_BACK, 0, 0);
		send_op(OP_DEL_POS, 0, 1);
		send_op(OP_SEARCH, 5, 0);
		send_op(OP_INS_POS, 9, 0);
		send_op(OP_INS_POS, 32'h7FFF_FFFF, 200);
		send_op(OP_DEL_FRONT, 0, 0);
		send_op(OP_INS_FRONT, 32'h8000_0000, 0);
		send_op(OP_INS_BACK, -1, 0);
		send_op(OP_INS_POS, 3, 1);
		send_op(OP_INS_POS, 4, 3);
		send_op(OP_INS_POS, 5, 255);
		send_op(OP_SEARCH, -1, 0);
		send_op(OP_SEARCH, 77, 0);
		send_op(OP_DEL_POS, 0, 0);
		send_op(OP_DEL_POS, 0, 2);
		send_op(OP_DEL_POS, 0, 255);
		send_op(3'd7, 32'h5555_AAAA, 8'hAA);
		send_op(OP_DEL_BACK, 0, 0);
		drain();
		// fill to capacity, with the receiver held off while the fill begins
		fork
			begin
				sink_hold = 1;
				repeat (300) @(posedge clk);
				sink_hold = 0;
			end
		join_none
		while (board.entries.size() < CAPACITY)
			send_op(OP_INS_POS, pick_value(), 8'($urandom_range(1, 255)));
		send_op(OP_INS_FRONT, 1, 0);
		send_op(OP_INS_POS, 2, 8'hFF);
		send_op(OP_INS_POS, 2, 0);
		send_op(OP_SEARCH, 32'h1234_5678, 0);
		drain();
		while (board.entries.size() > 40) send_op(OP_DEL_POS, 0, 8'($urandom_range(1, 255)));
		drain();
		repeat (260) random_op();
		quiet = 1;
		repeat (30) random_op();
		drain();
		repeat (2 * CAPACITY + 20) @(posedge clk);
		$display("Sent %0d operations, checked %0d results, including full and empty lists.",
			sent, board.checked);
		if (board.mismatches == 0 && board.pending.size() == 0)
			$display("** positional_list_manager: PASSED **");
		else
			$display("** positional_list_manager: FAILED **");
		$finish;
	end
endmodule
`default_nettype wire
